/* src/srec_pkg.sv */
// Package for the S-record stream parser: payload structs, result kind codes,
// character constants and the hex digit decoder.
// No dependencies.
package srec_pkg;

  // Result kinds, as carried in the kind field of a result.
  localparam logic [2:0] KIND_DATA      = 3'd0;
  localparam logic [2:0] KIND_COMMIT    = 3'd1;
  localparam logic [2:0] KIND_START     = 3'd2;
  localparam logic [2:0] KIND_END       = 3'd3;
  localparam logic [2:0] KIND_CSUM_ERR  = 3'd4;
  localparam logic [2:0] KIND_BAD_TYPE  = 3'd5;
  localparam logic [2:0] KIND_TRUNCATED = 3'd6;
  localparam logic [2:0] KIND_SHORT     = 3'd7;

  localparam logic [7:0]  CHAR_S       = 8'h53;
  localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
  localparam logic [15:0] COUNT_MIN    = 16'd5;
  localparam logic [15:0] LINE_MAX     = 16'hFFFF;
  localparam logic [3:0]  TYPE_DATA32  = 4'd3;
  localparam logic [3:0]  TYPE_START32 = 4'd7;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] record_address;
    logic [15:0] byte_offset;
    logic [7:0]  byte_value;
    logic [15:0] record_length;
    logic [3:0]  record_kind;
    logic [15:0] line_number;
  } out_t;

  // Any character that is not a hex digit decodes as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

/* src/srecord_stream_parser_core.sv */
// Top level of the S-record stream parser: decodes one character per transfer
// and registers at most one result per character.
// Depends on srec_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+---------------------
//   input   | in        | in_valid / in_ready    | srec_pkg::in_t
//   result  | out       | out_valid / out_ready  | srec_pkg::out_t
//   config  | in        | cfg_valid / cfg_ready  | cfg_data (wide_count)
//
// One character is taken every cycle unless the output stalls; its result,
// if any, appears in the cycle after the transfer, in the single output register.
// A new character is taken whenever that register is empty or is being read
// in the same cycle, so a stalled output stalls the input after one result.
// Synchronous reset returns the parser to the search for 'S' with line one;
// after any error or the end of text the parser ignores input until reset.
// Configuration writes are always taken.
module srecord_stream_parser_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  srec_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output srec_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);
  import srec_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_COUNT,
    PH_ADDR,
    PH_DATA,
    PH_CSUM
  } phase_t;

  phase_t      phase, phase_next;
  logic        wide_count;
  logic        halted, halted_next;
  logic [3:0]  high_nybble, high_nybble_next;
  logic        nybble_pos, nybble_pos_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] count_value, count_value_next;
  logic [31:0] address_value, address_value_next;
  logic [15:0] field_count, field_count_next;
  logic [3:0]  type_digit, type_digit_next;
  logic [15:0] line_counter, line_counter_next;

  logic        fire;
  logic        emit;
  out_t        result;
  logic [7:0]  byte_in;
  logic [7:0]  sum_in;
  logic [15:0] field_inc;
  logic [15:0] rec_len;
  logic [15:0] count_in;

  assign in_ready  = !out_valid || out_ready;
  assign cfg_ready = 1'b1;
  assign fire      = in_valid && in_ready;

  assign byte_in   = {high_nybble, hex_value(in_data.text_char)};
  assign sum_in    = running_sum + byte_in;
  assign field_inc = field_count + 16'd1;
  assign rec_len   = count_value - COUNT_MIN;
  assign count_in  = {count_value[7:0], byte_in};

  always_comb begin
    phase_next         = phase;
    halted_next        = halted;
    high_nybble_next   = high_nybble;
    nybble_pos_next    = nybble_pos;
    running_sum_next   = running_sum;
    count_value_next   = count_value;
    address_value_next = address_value;
    field_count_next   = field_count;
    type_digit_next    = type_digit;
    line_counter_next  = line_counter;
    emit               = 1'b0;
    result             = '0;
    result.line_number = line_counter;

    if (fire && !halted) begin
      if (in_data.end_of_text) begin
        halted_next = 1'b1;
        emit        = 1'b1;
        if (phase == PH_HUNT) begin
          result.kind = KIND_END;
        end else begin
          result.kind        = KIND_TRUNCATED;
          result.record_kind = type_digit;
        end
      end else if (phase == PH_HUNT) begin
        if (in_data.text_char == CHAR_NEWLINE && line_counter != LINE_MAX) begin
          line_counter_next = line_counter + 16'd1;
        end
        if (in_data.text_char == CHAR_S) begin
          phase_next         = PH_TYPE;
          running_sum_next   = 8'd1;
          count_value_next   = '0;
          address_value_next = '0;
          field_count_next   = '0;
          nybble_pos_next    = 1'b0;
          high_nybble_next   = '0;
        end
      end else if (phase == PH_TYPE) begin
        type_digit_next = hex_value(in_data.text_char);
        phase_next      = PH_COUNT;
      end else if (!nybble_pos) begin
        high_nybble_next = hex_value(in_data.text_char);
        nybble_pos_next  = 1'b1;
      end else begin
        // Second digit of a byte: the byte is complete and joins the checksum.
        nybble_pos_next  = 1'b0;
        running_sum_next = sum_in;
        unique case (phase)
          PH_COUNT: begin
            count_value_next = count_in;
            // The count width is taken from the register as it stands now.
            if (field_inc >= (wide_count ? 16'd2 : 16'd1)) begin
              field_count_next = '0;
              if (count_in < COUNT_MIN) begin
                halted_next        = 1'b1;
                emit               = 1'b1;
                result.kind        = KIND_SHORT;
                result.record_kind = type_digit;
              end else begin
                phase_next = PH_ADDR;
              end
            end else begin
              field_count_next = field_inc;
            end
          end
          PH_ADDR: begin
            address_value_next = {address_value[23:0], byte_in};
            if (field_inc >= 16'd4) begin
              field_count_next = '0;
              phase_next       = (rec_len == 16'd0) ? PH_CSUM : PH_DATA;
            end else begin
              field_count_next = field_inc;
            end
          end
          PH_DATA: begin
            if (type_digit == TYPE_DATA32) begin
              emit                  = 1'b1;
              result.kind           = KIND_DATA;
              result.record_address = address_value;
              result.byte_offset    = field_count;
              result.byte_value     = byte_in;
              result.record_length  = rec_len;
              result.record_kind    = type_digit;
            end
            if (field_inc >= rec_len) begin
              field_count_next = '0;
              phase_next       = PH_CSUM;
            end else begin
              field_count_next = field_inc;
            end
          end
          PH_CSUM: begin
            phase_next            = PH_HUNT;
            emit                  = 1'b1;
            result.record_address = address_value;
            result.record_length  = rec_len;
            result.record_kind    = type_digit;
            // The checksum is judged before the record type.
            priority if (sum_in != 8'd0) begin
              halted_next = 1'b1;
              result.kind = KIND_CSUM_ERR;
            end else if (type_digit == TYPE_DATA32) begin
              result.kind = KIND_COMMIT;
            end else if (type_digit == TYPE_START32) begin
              result.kind = KIND_START;
            end else begin
              halted_next = 1'b1;
              result.kind = KIND_BAD_TYPE;
            end
          end
          default: begin
            phase_next = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      halted       <= 1'b0;
      nybble_pos   <= 1'b0;
      running_sum  <= 8'd1;
      field_count  <= '0;
      line_counter <= 16'd1;
      type_digit   <= '0;
      wide_count   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      halted       <= halted_next;
      nybble_pos   <= nybble_pos_next;
      running_sum  <= running_sum_next;
      field_count  <= field_count_next;
      line_counter <= line_counter_next;
      type_digit   <= type_digit_next;
      if (cfg_valid && cfg_ready) begin
        wide_count <= cfg_data;
      end
      if (fire) begin
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Record fields are always loaded at 'S' before they are used.
  always_ff @(posedge clk) begin
    high_nybble   <= high_nybble_next;
    count_value   <= count_value_next;
    address_value <= address_value_next;
    if (fire && emit) begin
      out_data <= result;
    end
  end

`ifndef SYNTH
  a_halt_sticky : assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt released without reset");

  a_no_result_when_halted : assert property (@(posedge clk) disable iff (rst)
    (halted && !out_valid) |=> !out_valid)
    else $error("result produced while halted");

  a_error_halts : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.kind == KIND_END || out_data.kind == KIND_CSUM_ERR ||
                   out_data.kind == KIND_BAD_TYPE || out_data.kind == KIND_TRUNCATED ||
                   out_data.kind == KIND_SHORT)) |-> halted)
    else $error("terminal result without halt");

  a_offset_in_record : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind == KIND_DATA) |->
      (out_data.byte_offset < out_data.record_length &&
       out_data.record_kind == TYPE_DATA32))
    else $error("data byte outside its record");

  a_byte_aligned : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT || phase == PH_TYPE) |-> !nybble_pos)
    else $error("half byte pending outside a byte field");
`endif

endmodule

/* sim/srecord_stream_parser_core_tb.sv */
// Self-checking testbench for the S-record stream parser: builds S-record text, feeds it one
// character per transfer and checks every result against a predictor of the parser.
// Depends on srec_pkg and srecord_stream_parser_core.
module srecord_stream_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srec_pkg::*;

  typedef enum logic [2:0] {
    SEEK, TYPE_NYB, COUNT_FIELD, ADDR_FIELD, DATA_FIELD, SUM_FIELD
  } parse_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  srecord_stream_parser_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial forever #1 clk = ~clk;

  initial begin
    #4_000_000;
    $display("srecord_stream_parser_core_tb: errors");
    $finish;
  end

  // Predictor state.
  parse_phase_t p_phase;
  logic [3:0]   p_high;
  logic         p_second;
  logic [7:0]   p_sum;
  logic [15:0]  p_count;
  logic [31:0]  p_addr;
  logic [15:0]  p_field;
  logic [3:0]   p_type;
  logic [15:0]  p_line;
  logic         p_halted;
  logic         p_wide;

  out_t        srec_results_q[$];
  logic [7:0]  pending_text[$];
  int          fault_count = 0;
  int          idle_odds = 0;
  int          junk_odds = 0;
  int          stall_left = 0;
  logic        wide_now = 1'b0;

  function automatic logic [3:0] hex_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
    return 4'd0;
  endfunction

  function automatic void reset_parser_model();
    p_phase  = SEEK;
    p_high   = '0;
    p_second = 1'b0;
    p_sum    = 8'd1;
    p_count  = '0;
    p_addr   = '0;
    p_field  = '0;
    p_type   = '0;
    p_line   = 16'd1;
    p_halted = 1'b0;
    p_wide   = 1'b0;
  endfunction

  function automatic void parse_char(input in_t item);
    out_t        r;
    logic [3:0]  nv;
    logic [7:0]  b;
    logic [15:0] len;
    if (p_halted) return;
    r = '0;
    r.line_number = p_line;
    r.record_kind = p_type;
    nv = hex_of(item.text_char);
    if (item.end_of_text) begin
      p_halted = 1'b1;
      if (p_phase == SEEK) begin
        r.kind = KIND_END;
        r.record_kind = 4'd0;
      end else begin
        r.kind = KIND_TRUNCATED;
      end
      srec_results_q.push_back(r);
      return;
    end
    if (p_phase == SEEK) begin
      if (item.text_char == CHAR_NEWLINE && p_line != LINE_MAX) p_line++;
      if (item.text_char == CHAR_S) begin
        p_phase  = TYPE_NYB;
        p_sum    = 8'd1;
        p_count  = '0;
        p_addr   = '0;
        p_field  = '0;
        p_second = 1'b0;
        p_high   = '0;
      end
      return;
    end
    if (p_phase == TYPE_NYB) begin
      p_type  = nv;
      p_phase = COUNT_FIELD;
      return;
    end
    if (!p_second) begin
      p_high   = nv;
      p_second = 1'b1;
      return;
    end
    p_second = 1'b0;
    b = {p_high, nv};
    p_sum = p_sum + b;
    len = p_count - COUNT_MIN;
    case (p_phase)
      COUNT_FIELD: begin
        p_count = {p_count[7:0], b};
        p_field++;
        // The width is the one selected now, even if it changed part-way.
        if (p_field >= (p_wide ? 16'd2 : 16'd1)) begin
          p_field = '0;
          if (p_count < COUNT_MIN) begin
            p_halted = 1'b1;
            r.kind = KIND_SHORT;
            srec_results_q.push_back(r);
          end else begin
            p_phase = ADDR_FIELD;
          end
        end
      end
      ADDR_FIELD: begin
        p_addr = {p_addr[23:0], b};
        p_field++;
        if (p_field >= 16'd4) begin
          p_field = '0;
          p_phase = (len == 16'd0) ? SUM_FIELD : DATA_FIELD;
        end
      end
      DATA_FIELD: begin
        if (p_type == TYPE_DATA32) begin
          r.kind = KIND_DATA;
          r.record_address = p_addr;
          r.byte_offset = p_field;
          r.byte_value = b;
          r.record_length = len;
          srec_results_q.push_back(r);
        end
        p_field++;
        if (p_field >= len) begin
          p_field = '0;
          p_phase = SUM_FIELD;
        end
      end
      SUM_FIELD: begin
        p_phase = SEEK;
        r.record_address = p_addr;
        r.record_length = len;
        // The sum is judged before the record type.
        if (p_sum != 8'd0) begin
          p_halted = 1'b1;
          r.kind = KIND_CSUM_ERR;
        end else if (p_type == TYPE_DATA32) begin
          r.kind = KIND_COMMIT;
        end else if (p_type == TYPE_START32) begin
          r.kind = KIND_START;
        end else begin
          p_halted = 1'b1;
          r.kind = KIND_BAD_TYPE;
        end
        srec_results_q.push_back(r);
      end
      default: p_phase = SEEK;
    endcase
  endfunction

  function automatic void check_result(input out_t got);
    out_t want;
    if (srec_results_q.size() == 0) begin
      fault_count++;
      if (fault_count <= 10)
        $display("unexpected result at %0t: kind %0d line %0d", $realtime, got.kind,
                 got.line_number);
      return;
    end
    want = srec_results_q.pop_front();
    if (got.kind !== want.kind || got.record_address !== want.record_address ||
        got.byte_offset !== want.byte_offset || got.byte_value !== want.byte_value ||
        got.record_length !== want.record_length || got.record_kind !== want.record_kind ||
        got.line_number !== want.line_number) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected kind %0d addr %h offset %0d value %h length %0d type %0d line %0d",
                 want.kind, want.record_address, want.byte_offset, want.byte_value,
                 want.record_length, want.record_kind, want.line_number);
        $display("  actual   kind %0d addr %h offset %0d value %h length %0d type %0d line %0d",
                 got.kind, got.record_address, got.byte_offset, got.byte_value,
                 got.record_length, got.record_kind, got.line_number);
      end
    end
  endfunction

  // Results are checked before the character of the same edge is predicted.
  always @(posedge clk) begin
    if (rst) begin
      reset_parser_model();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) parse_char(in_data);
      if (cfg_valid && cfg_ready) p_wide = cfg_data;
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [7:0] noise_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_S);
    return c;
  endfunction

  // A zero nybble may be written as any non-hex character, line breaks included.
  function automatic logic [7:0] nyb_char(input logic [3:0] v);
    logic [7:0] c;
    if (v == 4'd0 && junk_odds != 0 && $urandom_range(1, junk_odds) == 1) begin
      case ($urandom_range(0, 3))
        0: c = CHAR_NEWLINE;
        1: c = 8'h0D;
        default: do c = 8'($urandom_range(0, 255)); while (hex_of(c) != 4'd0 || c == "0");
      endcase
    end else if (v < 4'd10) begin
      c = "0" + v;
    end else begin
      c = ($urandom_range(0, 1) ? "A" : "a") + v - 8'd10;
    end
    return c;
  endfunction

  function automatic void push_pair(input logic [7:0] b, inout logic [7:0] sum);
    pending_text.push_back(nyb_char(b[7:4]));
    pending_text.push_back(nyb_char(b[3:0]));
    sum = sum + b;
  endfunction

  // Appends one record; a count below the minimum stops the text after the count.
  function automatic void build_record(input logic [3:0] tdigit, input int cwidth,
                                       input logic [15:0] count, input logic [31:0] addr,
                                       input bit sum_ok);
    logic [7:0] sum;
    logic [7:0] b;
    sum = 8'd1;
    pending_text.push_back(CHAR_S);
    pending_text.push_back(nyb_char(tdigit));
    if (cwidth == 2) push_pair(count[15:8], sum);
    push_pair(count[7:0], sum);
    if (count < COUNT_MIN) return;
    for (int i = 0; i < 4; i++) push_pair(addr[31 - 8 * i -: 8], sum);
    for (int i = 0; i < count - 5; i++) begin
      b = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
      push_pair(b, sum);
    end
    b = 8'd0 - sum;
    if (!sum_ok) b = b ^ 8'($urandom_range(1, 255));
    push_pair(b, sum);
  endfunction

  function automatic void end_line();
    repeat ($urandom_range(0, 2)) pending_text.push_back(noise_char());
    if ($urandom_range(0, 1)) pending_text.push_back(8'h0D);
    pending_text.push_back(CHAR_NEWLINE);
  endfunction

  task automatic send_char(input logic [7:0] c, input logic eot);
    in_t item;
    item.text_char = c;
    item.end_of_text = eot;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_prefix(input int n);
    repeat (n) send_char(pending_text.pop_front(), 1'b0);
  endtask

  task automatic flush_text();
    while (pending_text.size() != 0) send_char(pending_text.pop_front(), 1'b0);
  endtask

  // Holds the input off until every predicted result has been read.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (srec_results_q.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_wide_count(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    wide_now = v;
  endtask

  task automatic test_directed_records();
    idle_odds = 6;
    junk_odds = 0;
    write_wide_count(1'b0);
    pending_text = '{8'h00, 8'hFF, CHAR_NEWLINE, 8'h73, 8'h0D, 8'h80, 8'h7F, CHAR_NEWLINE};
    build_record(TYPE_DATA32, 1, 16'd5, 32'h0000_0000, 1'b1);
    end_line();
    build_record(TYPE_DATA32, 1, 16'd8, 32'hFFFF_FFFF, 1'b1);
    end_line();
    junk_odds = 1;
    build_record(TYPE_DATA32, 1, 16'd13, 32'h0000_0000, 1'b1);
    junk_odds = 0;
    end_line();
    build_record(TYPE_START32, 1, 16'd5, $urandom, 1'b1);
    end_line();
    // Data bytes of a start record are consumed but never reported.
    build_record(TYPE_START32, 1, 16'd7, 32'hFFFF_FFFF, 1'b1);
    end_line();
    build_record(TYPE_DATA32, 1, 16'hFF, $urandom, 1'b1);
    end_line();
    flush_text();
  endtask

  task automatic test_wide_switch_mid_count();
    wait_for_results();
    write_wide_count(1'b1);
    build_record(TYPE_DATA32, 2, 16'd8, $urandom, 1'b1);
    send_prefix(4);
    wait_for_results();
    write_wide_count(1'b0);
    end_line();
    flush_text();
    wait_for_results();
    write_wide_count(1'b0);
    build_record(TYPE_DATA32, 2, 16'd7, $urandom, 1'b1);
    send_prefix(3);
    wait_for_results();
    write_wide_count(1'b1);
    end_line();
    flush_text();
  endtask

  task automatic test_random_stream();
    int          record_chars;
    int          len;
    int          pick;
    bit          paused;
    logic [15:0] cnt;
    for (int ph = 0; ph < 6; ph++) begin
      wait_for_results();
      write_wide_count(ph % 2 == 0);
      idle_odds = (ph == 5) ? 0 : ((ph % 2 != 0) ? 3 : 9);
      junk_odds = 6;
      record_chars = 0;
      paused = 1'b0;
      while (record_chars < 80) begin
        if (!paused && record_chars >= 40) begin
          wait_for_results();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
          repeat ($urandom_range(1, 8)) pending_text.push_back(noise_char());
        end else begin
          len = $urandom_range(0, 12);
          if ($urandom_range(0, 14) == 0) len = $urandom_range(13, 250);
          if (wide_now && $urandom_range(0, 24) == 0) len = $urandom_range(251, 320);
          cnt = 16'(len + 5);
          build_record((pick == 1) ? TYPE_START32 : TYPE_DATA32, wide_now ? 2 : 1, cnt,
                       $urandom, 1'b1);
          record_chars += pending_text.size();
        end
        end_line();
        flush_text();
      end
    end
  endtask

  // Every error and the end of text halt the parser until reset, so the run ends with one of them.
  task automatic test_terminal_error();
    logic [2:0]  ending;
    logic [3:0]  tdigit;
    logic [15:0] cnt;
    wait_for_results();
    write_wide_count(1'($urandom_range(0, 1)));
    ending = KIND_END + 3'($urandom_range(0, 4));
    cnt = 16'($urandom_range(0, 6) + 5);
    case (ending)
      KIND_END: begin
        repeat ($urandom_range(1, 4)) pending_text.push_back(noise_char());
        flush_text();
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      KIND_TRUNCATED: begin
        build_record($urandom_range(0, 1) ? TYPE_DATA32 : TYPE_START32, wide_now ? 2 : 1,
                     cnt, $urandom, 1'b1);
        send_prefix($urandom_range(1, pending_text.size() - 1));
        pending_text.delete();
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      KIND_SHORT: begin
        build_record(TYPE_DATA32, wide_now ? 2 : 1, 16'($urandom_range(0, 4)), 32'h0, 1'b1);
        flush_text();
      end
      KIND_CSUM_ERR: begin
        tdigit = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1)) tdigit = $urandom_range(0, 1) ? TYPE_DATA32 : TYPE_START32;
        build_record(tdigit, wide_now ? 2 : 1, cnt, $urandom, 1'b0);
        flush_text();
      end
      default: begin
        do tdigit = 4'($urandom_range(0, 15));
        while (tdigit == TYPE_DATA32 || tdigit == TYPE_START32);
        build_record(tdigit, wide_now ? 2 : 1, cnt, $urandom, 1'b1);
        flush_text();
      end
    endcase
    for (int i = 0; i < 6; i++) begin
      send_char(8'($urandom_range(0, 255)), (i == 5) || $urandom_range(0, 1));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed_records();
    test_wide_switch_mid_count();
    test_random_stream();
    test_terminal_error();
    wait_for_results();
    if (fault_count == 0) begin
      $display("srecord_stream_parser_core_tb: clean");
    end else begin
      $display("srecord_stream_parser_core_tb: errors");
    end
    $finish;
  end

endmodule
